// ===== sv/resistor_ladder_button_classifier_assert.svh =====
// Assertion helpers for the RTL modules; only rlbc_back includes them.
// Each macro expects clk and rst_n in the enclosing scope.
`ifndef RESISTOR_LADDER_BUTTON_CLASSIFIER_ASSERT_SVH
`define RESISTOR_LADDER_BUTTON_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define RLBC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RLBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rlbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rlbc_pkg;

  localparam int unsigned CFG_W     = 20;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned ADC_W  = 12;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned SEC_W  = 23;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  localparam int unsigned TICK_INTERVAL_MS_DEF = 1000;
  localparam int unsigned QUEUE_DEPTH_DEF      = 2;

  localparam logic [TIME_W-1:0] MS_PER_SECOND = 32'd1000;
  // held / 1000 == (held * SEC_RECIP) >> SEC_SHIFT for every 32-bit held
  localparam logic [31:0] SEC_RECIP = 32'd2199023256;
  localparam int unsigned SEC_SHIFT = 41;

  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_ONE   = 2'd1;
  localparam logic [1:0] BTN_TWO   = 2'd2;
  localparam logic [1:0] BTN_THREE = 2'd3;

  localparam logic [CODE_W-1:0] EV_B1_SHORT  = 4'd0;
  localparam logic [CODE_W-1:0] EV_B1_LONG1  = 4'd1;
  localparam logic [CODE_W-1:0] EV_B1_LONG2  = 4'd2;
  localparam logic [CODE_W-1:0] EV_B1_LONG3  = 4'd3;
  localparam logic [CODE_W-1:0] EV_B2_SINGLE = 4'd4;
  localparam logic [CODE_W-1:0] EV_B2_DOUBLE = 4'd5;
  localparam logic [CODE_W-1:0] EV_B3_SINGLE = 4'd6;
  localparam logic [CODE_W-1:0] EV_B3_DOUBLE = 4'd7;
  localparam logic [CODE_W-1:0] EV_TICK      = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_FIRST  = 3'd0,
    REG_LIMIT_SECOND = 3'd1,
    REG_LIMIT_THIRD  = 3'd2,
    REG_DEBOUNCE     = 3'd3,
    REG_HOLD_ONE     = 3'd4,
    REG_HOLD_TWO     = 3'd5,
    REG_HOLD_THREE   = 3'd6,
    REG_TAP_WINDOW   = 3'd7
  } cfg_reg_t;

  // Events caused by one poll, in delivery order: release, b2 single,
  // b3 single, tick.
  typedef struct packed {
    logic                rel_vld;
    logic [CODE_W-1:0]   rel_code;
    logic                b2_single;
    logic                b3_single;
    logic                tick;
    logic [TIME_W-1:0]   held_ms;
  } bundle_t;

endpackage
`default_nettype wire

// ===== sv/rlbc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rlbc_front #(
  parameter int unsigned TICK_INTERVAL_MS = rlbc_pkg::TICK_INTERVAL_MS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rlbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rlbc_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [rlbc_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                             q_full,
  output logic                                  push,
  output rlbc_pkg::bundle_t                     push_data
);

  localparam logic [rlbc_pkg::TIME_W-1:0] TICK_MS = rlbc_pkg::TIME_W'(TICK_INTERVAL_MS);

  function automatic logic [1:0] decode(input logic [11:0] s, input logic [11:0] l1,
                                        input logic [11:0] l2, input logic [11:0] l3);
    logic [1:0] b;
    if (s < l1)      b = rlbc_pkg::BTN_ONE;
    else if (s < l2) b = rlbc_pkg::BTN_TWO;
    else if (s < l3) b = rlbc_pkg::BTN_THREE;
    else             b = rlbc_pkg::BTN_NONE;
    return b;
  endfunction

  // configuration
  logic [11:0] lim1_r, lim2_r, lim3_r;
  logic [15:0] deb_r, win_r;
  logic [19:0] hold1_r, hold2_r, hold3_r;

  // classifier state
  logic [1:0]  cand_r, cand_nxt, settled_r, settled_nxt, heldb_r, heldb_nxt;
  logic [31:0] since_r, since_nxt, press_r, press_nxt, last_r, last_nxt;
  logic        armed_r, armed_nxt, w2_r, w2_nxt, w3_r, w3_nxt;
  logic [31:0] t2_r, t2_nxt, t3_r, t3_nxt;

  logic [31:0] now, since_diff, held, t2_diff, t3_diff, tick_diff;
  logic [11:0] sample;
  logic [1:0]  btn;
  logic        acc, cand_chg, stable_ok, settle, press, rel, dbl2, dbl3;
  logic [rlbc_pkg::CODE_W-1:0] b1_code;
  rlbc_pkg::bundle_t bnd;

  assign now        = in_tdata[31:0];
  assign sample     = in_tdata[43:32];
  assign in_tready  = !q_full;
  assign acc        = in_tvalid && in_tready;
  assign btn        = decode(sample, lim1_r, lim2_r, lim3_r);
  assign since_diff = now - since_r;
  assign held       = now - press_r;
  assign t2_diff    = now - t2_r;
  assign t3_diff    = now - t3_r;
  assign tick_diff  = now - last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim1_r  <= 12'd1000;
      lim2_r  <= 12'd2000;
      lim3_r  <= 12'd3000;
      deb_r   <= 16'd30;
      hold1_r <= 20'd2000;
      hold2_r <= 20'd4000;
      hold3_r <= 20'd10000;
      win_r   <= 16'd300;
    end else if (cfg_we) begin
      case (rlbc_pkg::cfg_reg_t'(cfg_index))
        rlbc_pkg::REG_LIMIT_FIRST:  lim1_r  <= cfg_wdata[11:0];
        rlbc_pkg::REG_LIMIT_SECOND: lim2_r  <= cfg_wdata[11:0];
        rlbc_pkg::REG_LIMIT_THIRD:  lim3_r  <= cfg_wdata[11:0];
        rlbc_pkg::REG_DEBOUNCE:     deb_r   <= cfg_wdata[15:0];
        rlbc_pkg::REG_HOLD_ONE:     hold1_r <= cfg_wdata[19:0];
        rlbc_pkg::REG_HOLD_TWO:     hold2_r <= cfg_wdata[19:0];
        rlbc_pkg::REG_HOLD_THREE:   hold3_r <= cfg_wdata[19:0];
        rlbc_pkg::REG_TAP_WINDOW:   win_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cand_chg  = btn != cand_r;
    // a fresh candidate has zero age, so it settles only with no debounce time
    stable_ok = cand_chg ? (deb_r == 16'd0) : (since_diff >= {16'd0, deb_r});
    settle    = (btn != settled_r) && stable_ok;
    press     = settle && (settled_r == rlbc_pkg::BTN_NONE);
    rel       = settle && (btn == rlbc_pkg::BTN_NONE);
    dbl2      = w2_r && (t2_diff <= {16'd0, win_r});
    dbl3      = w3_r && (t3_diff <= {16'd0, win_r});

    if (held >= {12'd0, hold3_r})      b1_code = rlbc_pkg::EV_B1_LONG3;
    else if (held >= {12'd0, hold2_r}) b1_code = rlbc_pkg::EV_B1_LONG2;
    else if (held >= {12'd0, hold1_r}) b1_code = rlbc_pkg::EV_B1_LONG1;
    else                               b1_code = rlbc_pkg::EV_B1_SHORT;

    cand_nxt    = cand_r;
    since_nxt   = since_r;
    settled_nxt = settled_r;
    heldb_nxt   = heldb_r;
    press_nxt   = press_r;
    last_nxt    = last_r;
    armed_nxt   = armed_r;
    w2_nxt      = w2_r;
    t2_nxt      = t2_r;
    w3_nxt      = w3_r;
    t3_nxt      = t3_r;
    bnd         = '0;
    bnd.held_ms = held;

    if (acc) begin
      if (cand_chg) begin
        cand_nxt  = btn;
        since_nxt = now;
      end
      if (settle) settled_nxt = btn;
      if (press) begin
        heldb_nxt = btn;
        press_nxt = now;
        last_nxt  = now;
        armed_nxt = 1'b1;
      end
      if (rel) begin
        heldb_nxt = rlbc_pkg::BTN_NONE;
        last_nxt  = 32'd0;
        armed_nxt = 1'b0;
        case (settled_r)
          rlbc_pkg::BTN_ONE: begin
            bnd.rel_vld  = 1'b1;
            bnd.rel_code = b1_code;
          end
          rlbc_pkg::BTN_TWO: begin
            if (dbl2) begin
              w2_nxt       = 1'b0;
              bnd.rel_vld  = 1'b1;
              bnd.rel_code = rlbc_pkg::EV_B2_DOUBLE;
            end else begin
              w2_nxt = 1'b1;
              t2_nxt = now;
            end
          end
          rlbc_pkg::BTN_THREE: begin
            if (dbl3) begin
              w3_nxt       = 1'b0;
              bnd.rel_vld  = 1'b1;
              bnd.rel_code = rlbc_pkg::EV_B3_DOUBLE;
            end else begin
              w3_nxt = 1'b1;
              t3_nxt = now;
            end
          end
          default: ;
        endcase
      end
      // a window touched by this release cannot expire in the same poll
      if (w2_r && !(rel && settled_r == rlbc_pkg::BTN_TWO) && t2_diff > {16'd0, win_r}) begin
        w2_nxt        = 1'b0;
        bnd.b2_single = 1'b1;
      end
      if (w3_r && !(rel && settled_r == rlbc_pkg::BTN_THREE) && t3_diff > {16'd0, win_r}) begin
        w3_nxt        = 1'b0;
        bnd.b3_single = 1'b1;
      end
      // a press or a release in this poll leaves no tick
      if (!press && !rel && heldb_r == rlbc_pkg::BTN_ONE && armed_r &&
          held >= rlbc_pkg::MS_PER_SECOND && tick_diff >= TICK_MS) begin
        last_nxt = now;
        bnd.tick = 1'b1;
      end
    end
  end

  assign push      = acc && (bnd.rel_vld || bnd.b2_single || bnd.b3_single || bnd.tick);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r    <= rlbc_pkg::BTN_NONE;
      since_r   <= 32'd0;
      settled_r <= rlbc_pkg::BTN_NONE;
      heldb_r   <= rlbc_pkg::BTN_NONE;
      press_r   <= 32'd0;
      last_r    <= 32'd0;
      armed_r   <= 1'b0;
      w2_r      <= 1'b0;
      t2_r      <= 32'd0;
      w3_r      <= 1'b0;
      t3_r      <= 32'd0;
    end else begin
      cand_r    <= cand_nxt;
      since_r   <= since_nxt;
      settled_r <= settled_nxt;
      heldb_r   <= heldb_nxt;
      press_r   <= press_nxt;
      last_r    <= last_nxt;
      armed_r   <= armed_nxt;
      w2_r      <= w2_nxt;
      t2_r      <= t2_nxt;
      w3_r      <= w3_nxt;
      t3_r      <= t3_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rlbc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rlbc_queue #(
  parameter int unsigned DEPTH = rlbc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rlbc_pkg::bundle_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output rlbc_pkg::bundle_t      head,
  output logic                   nonempty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rlbc_pkg::bundle_t mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == FULL_CNT;
  assign nonempty = cnt_r != '0;
  assign head     = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rlbc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "resistor_ladder_button_classifier_assert.svh"
module rlbc_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_nonempty,
  input  wire rlbc_pkg::bundle_t                 head,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [rlbc_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [rlbc_pkg::CODE_W-1:0]            out_tuser,
  output logic                                   out_tlast
);

  // pending mask: bit 0 release, 1 b2 single, 2 b3 single, 3 tick
  logic [3:0]  pend_r, pend_nxt, pend_left, sel;
  logic [rlbc_pkg::CODE_W-1:0] rcode_r, rcode_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic        ov_r, ov_nxt, last_r, last_nxt, load_out;
  logic [rlbc_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [rlbc_pkg::SEC_W-1:0]  secs_r, secs_nxt;

  assign load_out = !ov_r || out_tready;
  assign sel      = pend_r & (~pend_r + 4'd1);

  always_comb begin
    ov_nxt    = ov_r;
    code_nxt  = code_r;
    secs_nxt  = secs_r;
    last_nxt  = last_r;
    pend_left = pend_r;
    if (load_out) begin
      if (pend_r != 4'd0) begin
        ov_nxt    = 1'b1;
        pend_left = pend_r & ~sel;
        last_nxt  = (pend_r & ~sel) == 4'd0;
        secs_nxt  = '0;
        if (sel[0])      code_nxt = rcode_r;
        else if (sel[1]) code_nxt = rlbc_pkg::EV_B2_SINGLE;
        else if (sel[2]) code_nxt = rlbc_pkg::EV_B3_SINGLE;
        else begin
          code_nxt = rlbc_pkg::EV_TICK;
          secs_nxt = prod_r[rlbc_pkg::SEC_SHIFT +: rlbc_pkg::SEC_W];
        end
      end else begin
        ov_nxt = 1'b0;
      end
    end
    // take the next poll's events once the current ones are all handed out
    pop       = q_nonempty && (pend_left == 4'd0);
    pend_nxt  = pend_left;
    rcode_nxt = rcode_r;
    prod_nxt  = prod_r;
    if (pop) begin
      pend_nxt  = {head.tick, head.b3_single, head.b2_single, head.rel_vld};
      rcode_nxt = head.rel_code;
      prod_nxt  = 64'(head.held_ms) * 64'(rlbc_pkg::SEC_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rcode_r <= rcode_nxt;
    prod_r  <= prod_nxt;
    code_r  <= code_nxt;
    secs_r  <= secs_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, secs_r};
  assign out_tuser  = code_r;
  assign out_tlast  = last_r;

  `RLBC_ASSERT_SAME(a_secs_tick_only, out_tvalid && out_tuser != rlbc_pkg::EV_TICK, out_tdata == '0, "held seconds on a non-tick word")
  `RLBC_ASSERT_NEXT(a_run_unbroken, out_tvalid && out_tready && !out_tlast, out_tvalid, "run of results broken before its last word")
  `RLBC_ASSERT_NEXT(a_pop_has_events, pop, pend_r != 4'd0, "popped a poll with no events")

endmodule
`default_nettype wire

// ===== sv/resistor_ladder_button_classifier.sv =====
// Resistor-ladder button classifier.
// in_*  : one word per poll; in_tdata = time_ms [31:0], adc_sample [43:32].
// out_* : one word per event; out_tuser = event_code, out_tdata = held_seconds,
//         out_tlast marks the last event caused by a poll. Polls that cause
//         no event give no word.
// cfg_* : write port, eight registers by index (limits, debounce, hold levels,
//         tap window); user writes only while the block is idle (not enforced).
// The front end decodes, debounces and classifies one poll per cycle and
// drops its events for that poll into a short queue; in_tready falls only
// when that queue is full. The back end pops one poll's events, registers the
// held-seconds product, and hands out one word per cycle from an output
// register. The first word of a poll passes through the queue, the pending
// mask register and the output register; the sustained rate is set by the
// output port at one word per cycle (up to 3 per poll).
// When out_tready is low the output word holds, the back end waits, and the
// queue fills before the input stalls.
// Reset (rst_n low, synchronous) restores register defaults, clears all
// button state, empties the queue and drops any word not yet taken.
`timescale 1ns / 1ps
`default_nettype none
module resistor_ladder_button_classifier #(
  parameter int unsigned TICK_INTERVAL_MS = rlbc_pkg::TICK_INTERVAL_MS_DEF,
  parameter int unsigned QUEUE_DEPTH      = rlbc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rlbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rlbc_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // time_ms [31:0], adc_sample [43:32], zero [47:44]
  input  wire logic [rlbc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // held_seconds [22:0], zero [23]
  output logic [rlbc_pkg::OUT_DATA_W-1:0]      out_tdata,
  // event_code [3:0]
  output logic [rlbc_pkg::CODE_W-1:0]          out_tuser,
  output logic                                 out_tlast
);

  logic              q_full, q_nonempty, push, pop;
  rlbc_pkg::bundle_t push_data, head;

  // decode, debounce and classify; hold the poll when the queue is full
  rlbc_front #(
    .TICK_INTERVAL_MS(TICK_INTERVAL_MS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decouple classification from delivery
  rlbc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .nonempty  (q_nonempty)
  );

  // serialize each poll's events onto the result channel
  rlbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== verif/resistor_ladder_button_classifier_tb.sv =====
`timescale 1ns / 1ps
module resistor_ladder_button_classifier_tb;
  import rlbc_pkg::*;

  // Cycles without any accepted word before the run is called hung.
  localparam int STALL_LIMIT = 4000;
  // Quiet cycles after the last event word, before a register write or the end.
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_POLLS = 54;
  localparam logic [TIME_W-1:0] TICK_MS = TICK_INTERVAL_MS_DEF;

  typedef struct {
    logic [TIME_W-1:0] stamp;
    logic [ADC_W-1:0]  adc;
    bit                drain;  // hold this poll back until every event is out
  } poll_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [SEC_W-1:0]  secs;
    logic              last;
  } button_event_t;

  typedef enum {RX_OPEN, RX_BUSY_LIGHT, RX_BUSY_HEAVY, RX_PULSED} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_LIMIT_FIRST;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [CODE_W-1:0] out_tuser;
  logic out_tlast;

  resistor_ladder_button_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // time_ms [31:0], adc_sample [43:32], zero [47:44]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // held_seconds [22:0], zero [23]
    .out_tuser  (out_tuser),  // event_code [3:0]
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Register copy and button state of the predictor. Registers start at their
  // reset values and are updated whenever the write port is used.
  // ---------------------------------------------------------------------------
  logic [ADC_W-1:0]  lim_first = 12'd1000;
  logic [ADC_W-1:0]  lim_second = 12'd2000;
  logic [ADC_W-1:0]  lim_third = 12'd3000;
  logic [15:0]       debounce_ms = 16'd30;
  logic [19:0]       hold_one = 20'd2000;
  logic [19:0]       hold_two = 20'd4000;
  logic [19:0]       hold_three = 20'd10000;
  logic [15:0]       tap_window = 16'd300;

  logic [1:0]        cand_btn = BTN_NONE;
  logic [TIME_W-1:0] cand_since = '0;
  logic [1:0]        stable_btn = BTN_NONE;
  logic [1:0]        pressed_btn = BTN_NONE;
  logic [TIME_W-1:0] press_at = '0;
  logic [TIME_W-1:0] tick_at = '0;
  bit                tick_on = 1'b0;
  bit                b2_wait = 1'b0;
  logic [TIME_W-1:0] b2_at = '0;
  bit                b3_wait = 1'b0;
  logic [TIME_W-1:0] b3_at = '0;

  button_event_t pending_events[$];
  poll_t         poll_queue[$];
  logic [CFG_W-1:0] next_settings [8];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int phase_items = 0;
  logic [TIME_W-1:0] stim_now = '0;
  bit poll_taken = 1'b0;

  function automatic logic [1:0] ladder_decode(input logic [ADC_W-1:0] adc);
    if (adc < lim_first) return BTN_ONE;
    if (adc < lim_second) return BTN_TWO;
    if (adc < lim_third) return BTN_THREE;
    return BTN_NONE;
  endfunction

  function automatic button_event_t make_event(input logic [CODE_W-1:0] code,
                                               input logic [SEC_W-1:0] secs);
    button_event_t ev;
    ev.code = code;
    ev.secs = secs;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Work out the events of one accepted poll and queue them in delivery
  // order: release, button 2 single, button 3 single, hold tick.
  task automatic classify_poll(input logic [TIME_W-1:0] now, input logic [ADC_W-1:0] adc);
    logic [1:0] btn;
    logic [1:0] prev;
    logic [TIME_W-1:0] held;
    button_event_t evs[$];
    btn = ladder_decode(adc);
    if (btn != cand_btn) begin
      cand_btn = btn;
      cand_since = now;
    end
    // Debounce: a new reading becomes stable only after it has persisted.
    if (btn != stable_btn && (now - cand_since) >= debounce_ms) begin
      prev = stable_btn;
      stable_btn = btn;
      if (prev == BTN_NONE) begin
        pressed_btn = btn;
        press_at = now;
        tick_at = now;
        tick_on = 1'b1;
      end else if (btn == BTN_NONE) begin
        // Release is classified by the button settled last.
        held = now - press_at;
        case (prev)
          BTN_ONE: begin
            if (held >= hold_three) evs.push_back(make_event(EV_B1_LONG3, '0));
            else if (held >= hold_two) evs.push_back(make_event(EV_B1_LONG2, '0));
            else if (held >= hold_one) evs.push_back(make_event(EV_B1_LONG1, '0));
            else evs.push_back(make_event(EV_B1_SHORT, '0));
          end
          BTN_TWO: begin
            if (b2_wait && (now - b2_at) <= tap_window) begin
              b2_wait = 1'b0;
              evs.push_back(make_event(EV_B2_DOUBLE, '0));
            end else begin
              b2_wait = 1'b1;
              b2_at = now;
            end
          end
          BTN_THREE: begin
            if (b3_wait && (now - b3_at) <= tap_window) begin
              b3_wait = 1'b0;
              evs.push_back(make_event(EV_B3_DOUBLE, '0));
            end else begin
              b3_wait = 1'b1;
              b3_at = now;
            end
          end
          default: ;
        endcase
        pressed_btn = BTN_NONE;
        tick_at = '0;
        tick_on = 1'b0;
      end
    end
    // Tap window ran out with no second tap: give the single.
    if (b2_wait && (now - b2_at) > tap_window) begin
      b2_wait = 1'b0;
      evs.push_back(make_event(EV_B2_SINGLE, '0));
    end
    if (b3_wait && (now - b3_at) > tap_window) begin
      b3_wait = 1'b0;
      evs.push_back(make_event(EV_B3_SINGLE, '0));
    end
    if (pressed_btn == BTN_ONE && tick_on) begin
      held = now - press_at;
      if (held >= MS_PER_SECOND && (now - tick_at) >= TICK_MS) begin
        tick_at = now;
        evs.push_back(make_event(EV_TICK, SEC_W'(held / MS_PER_SECOND)));
      end
    end
    if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Check event words first,
  // then predict from the poll accepted on the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    button_event_t want;
    string diffs;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("event word with none pending: code %0d secs %0d",
                                    out_tuser, out_tdata));
        end else begin
          want = pending_events.pop_front();
          diffs = "";
          if (out_tuser !== want.code)
            diffs = {diffs, $sformatf(" code %0d/%0d", out_tuser, want.code)};
          if (out_tdata !== {1'b0, want.secs})
            diffs = {diffs, $sformatf(" secs %0d/%0d", out_tdata, want.secs)};
          if (out_tlast !== want.last)
            diffs = {diffs, $sformatf(" last %0b/%0b", out_tlast, want.last)};
          if (diffs != "") report_mismatch({"event word differs (got/want):", diffs});
        end
      end
      if (in_tvalid && in_tready) begin
        classify_poll(in_tdata[TIME_W-1:0], in_tdata[TIME_W +: ADC_W]);
        poll_taken = 1'b1;
      end
      // Watchdog: count edges where neither channel moves a word.
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: send polls in bursts of random length with random gaps. Hold the
  // current word until it is taken; hold back a poll marked for draining until
  // every pending event has been delivered.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;
  poll_t next_poll;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !poll_taken) begin
        // hold the word until accepted
      end else if (gap_left > 0) begin
        poll_taken = 1'b0;
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (poll_queue.size() != 0 &&
                   !(poll_queue[0].drain && pending_events.size() != 0)) begin
        poll_taken = 1'b0;
        next_poll = poll_queue.pop_front();
        in_tdata <= {4'b0000, next_poll.adc, next_poll.stamp};
        in_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(16, 1);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
        end
      end else begin
        poll_taken = 1'b0;
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a pattern that is picked anew at random from time to time,
  // including stretches where it never stalls.
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(3, 0));
      rx_left = $urandom_range(80, 10);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:       out_tready <= 1'b1;
      RX_BUSY_LIGHT: out_tready <= ($urandom_range(3, 0) != 0);
      RX_BUSY_HEAVY: out_tready <= ($urandom_range(3, 0) == 0);
      default:       out_tready <= rx_left[2];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void apply_setting(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
    case (idx)
      REG_LIMIT_FIRST:  lim_first = v[ADC_W-1:0];
      REG_LIMIT_SECOND: lim_second = v[ADC_W-1:0];
      REG_LIMIT_THIRD:  lim_third = v[ADC_W-1:0];
      REG_DEBOUNCE:     debounce_ms = v[15:0];
      REG_HOLD_ONE:     hold_one = v;
      REG_HOLD_TWO:     hold_two = v;
      REG_HOLD_THREE:   hold_three = v;
      REG_TAP_WINDOW:   tap_window = v[15:0];
      default: ;
    endcase
  endfunction

  // Write all eight registers, one per cycle, then drop the write enable.
  task automatic load_settings();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= next_settings[i];
      apply_setting(cfg_reg_t'(i), next_settings[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every poll is sent and every event delivered, then let the
  // block finish any poll that produced nothing.
  task automatic wait_drained();
    while (poll_queue.size() != 0 || in_tvalid || pending_events.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic add_at(input logic [TIME_W-1:0] stamp, input logic [ADC_W-1:0] adc,
                        input bit drain = 1'b0);
    poll_t p;
    p.stamp = stamp;
    p.adc = adc;
    p.drain = drain;
    stim_now = stamp;
    poll_queue.push_back(p);
    phase_items++;
  endtask

  task automatic add_after(input int step, input logic [ADC_W-1:0] adc);
    add_at(stim_now + TIME_W'(step), adc, ($urandom_range(39, 0) == 0));
  endtask

  // Pick a reading that decodes as the given button under the current
  // limits; fall back to an idle reading when that button's range is empty.
  function automatic logic [ADC_W-1:0] sample_for(input logic [1:0] btn);
    int lo;
    int top;
    lo = (lim_first > lim_second) ? lim_first : lim_second;
    top = (lo > lim_third) ? lo : lim_third;
    case (btn)
      BTN_ONE:
        if (lim_first != 0) return ADC_W'($urandom_range(lim_first - 1, 0));
      BTN_TWO:
        if (lim_second > lim_first) return ADC_W'($urandom_range(lim_second - 1, lim_first));
      BTN_THREE:
        if (lim_third > lo) return ADC_W'($urandom_range(lim_third - 1, lo));
      default: ;
    endcase
    return ADC_W'($urandom_range(4095, top));
  endfunction

  // One press: contact bounce, a settled press, a hold (maybe sliding onto
  // another button), a settled release and sometimes a quiet poll after it.
  task automatic gen_press(input logic [1:0] btn);
    int deb;
    int hold;
    int k;
    int rest;
    logic [TIME_W-1:0] press_stamp;
    logic [1:0] other;
    deb = int'(debounce_ms);
    repeat ($urandom_range(2, 0))
      add_after((deb > 0) ? int'($urandom_range(deb - 1, 0)) : int'($urandom_range(3, 0)),
                ADC_W'($urandom));
    add_after($urandom_range(20, 1), sample_for(btn));
    add_after(deb, sample_for(btn));
    press_stamp = stim_now;
    if (btn == BTN_ONE) begin
      case ($urandom_range(3, 0))
        0:       hold = int'(hold_one);
        1:       hold = int'(hold_two);
        2:       hold = int'(hold_three);
        default: hold = $urandom_range(2500, 0);
      endcase
      // land exactly on a level half of the time, near it otherwise
      if ($urandom_range(1, 0) == 0) hold = hold + int'($urandom_range(600, 0)) - 300;
      if (hold < 0) hold = 0;
    end else begin
      hold = $urandom_range(400, 0);
    end
    k = $urandom_range(4, 1);
    repeat (k) add_after(hold / (k + 1), sample_for(btn));
    if ($urandom_range(5, 0) == 0) begin
      other = 2'($urandom_range(3, 1));
      add_after(5, sample_for(other));
      add_after(deb, sample_for(other));
    end
    add_after(1, sample_for(BTN_NONE));
    rest = hold - int'(stim_now - press_stamp);
    if (rest < deb) rest = deb;
    add_after(rest, sample_for(BTN_NONE));
    if ($urandom_range(1, 0) == 0)
      add_after(($urandom_range(1, 0) == 0) ? int'($urandom_range(tap_window, 0))
                                             : int'(tap_window) + int'($urandom_range(500, 1)),
                sample_for(BTN_NONE));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed polls at reset settings, then six phases of
  // random presses, each under its own register settings.
  // ---------------------------------------------------------------------------
  initial begin
    int a;
    int b;
    int c;
    int h1;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // threshold edges: 0 and 999 decode as button 1, 1000 and 1999 as
    // button 2, 2999 as button 3, 3000 and 4095 as none
    add_at(32'd100, 12'd0);                   // short press of button 1
    add_at(32'd130, 12'd0);
    add_at(32'd200, 12'd4095);
    add_at(32'd230, 12'd4095);
    add_at(32'd1000, 12'd999);                // long hold with ticks
    add_at(32'd1030, 12'd999);
    add_at(32'd2030, 12'd999);
    add_at(32'd3030, 12'd999);
    add_at(32'd4100, 12'd999);
    add_at(32'd4200, 12'd4095);
    add_at(32'd4230, 12'd4095);
    add_at(32'd5000, 12'd1000);               // double tap on button 2
    add_at(32'd5030, 12'd1000);
    add_at(32'd5100, 12'd4095);
    add_at(32'd5130, 12'd4095);
    add_at(32'd5150, 12'd1999);
    add_at(32'd5180, 12'd1999);
    add_at(32'd5200, 12'd4095);
    add_at(32'd5230, 12'd4095);
    add_at(32'd6000, 12'd2999);               // press 3, slide onto 2, release
    add_at(32'd6030, 12'd2999);
    add_at(32'd6060, 12'd1500);
    add_at(32'd6090, 12'd1500);
    add_at(32'd6130, 12'd3000);
    add_at(32'd6160, 12'd3000);
    add_at(32'd6500, 12'd3000);               // window passes: button 2 single
    wait_drained();

    for (int phase = 1; phase <= 6; phase++) begin
      case (phase)
        1: begin
          a = $urandom_range(1500, 200);
          b = a + $urandom_range(1200, 100);
          c = b + $urandom_range(1200, 100);
          h1 = $urandom_range(2500, 500);
          next_settings = '{20'(a), 20'(b), 20'(c), 20'($urandom_range(60, 0)), 20'(h1),
                            20'(h1 + 1000), 20'(h1 + 1000 + $urandom_range(6000, 500)),
                            20'($urandom_range(600, 50))};
        end
        // lowest corner: button 1 and 3 ranges empty, no debounce, zero window
        2: next_settings = '{20'd0, 20'd4095, 20'd4095, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0};
        // highest corner
        3: next_settings = '{20'd4095, 20'd4095, 20'd4095, 20'd65535, 20'hFFFFF, 20'hFFFFF,
                             20'hFFFFF, 20'd65535};
        // unordered limits and hold levels
        4: begin
          a = $urandom_range(3500, 2000);
          next_settings = '{20'(a), 20'($urandom_range(1500, 0)), 20'($urandom_range(4000, a)),
                            20'($urandom_range(40, 0)), 20'($urandom_range(6000, 3000)),
                            20'($urandom_range(3000, 0)), 20'($urandom_range(6000, 0)),
                            20'($urandom_range(1000, 0))};
        end
        // full-width random words: bits above each register's width drop
        5: for (int i = 0; i < 8; i++) next_settings[i] = CFG_W'($urandom);
        default:
          next_settings = '{20'd1000, 20'd2000, 20'd3000, 20'd30, 20'd2000, 20'd4000,
                            20'd10000, 20'd300};
      endcase
      load_settings();
      if (phase == 1) stim_now = $urandom;
      if (phase == 5) stim_now = 32'hFFFF_FFFF - TIME_W'($urandom_range(30000, 0));
      phase_items = 0;
      while (phase_items < PHASE_POLLS) begin
        case ($urandom_range(15, 0))
          0, 1: add_after($urandom_range(3000, 0), ADC_W'($urandom));
          2:    add_at($urandom, ADC_W'($urandom));
          default: gen_press(2'($urandom_range(3, 1)));
        endcase
      end
      // in phase 3, hold off the first poll of the phase until the block has drained
      if (phase == 3) poll_queue[0].drain = 1'b1;
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
